[sv/ohmp_pkg.sv]
// ----------------------------------------------------------------------------
// ohmp_pkg: shared types and constants
// Item types, mode codes and sizes for the orientation histogram mode picker.
// ----------------------------------------------------------------------------
`default_nettype none

package ohmp_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int MAX_BINS   = 1024;
	localparam int PT_W       = $clog2(MAX_POINTS);
	localparam int BIN_W      = $clog2(MAX_BINS);
	localparam int CNT_W      = 11;

	// quantizer divisors: 8192*314 and 8192*628
	localparam int QDIV_X = 8192 * 314;
	localparam int QDIV_Y = 8192 * 628;
	localparam int QOFS_Y = 8192 * 314;

	// both divisors are 157 times a power of two: shift, then multiply by
	// 2^20/157 rounded up, exact for the 13-bit shifted operands
	localparam int QSH_X     = 14;
	localparam int QSH_Y     = 15;
	localparam int QRECIP    = 6679;
	localparam int QRECIP_SH = 20;

	localparam logic [5:0] BINS_RESET = 6'd20;

	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_SELECT = 3'd1;
	localparam logic [2:0] MODE_NEXT   = 3'd2;
	localparam logic [2:0] MODE_REMOVE = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [15:0] polar_angle;
		logic signed [15:0] azimuth_angle;
		logic               point_valid;
		logic [9:0]         remove_id;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [9:0]  bin_index;
		logic [10:0] bin_count;
		logic [9:0]  member_id;
		logic        scan_done;
	} out_item_t;

	typedef struct packed {
		logic               start;
		logic signed [15:0] polar;
		logic signed [15:0] azimuth;
		logic [4:0]         k;
		logic [5:0]         n;
	} quant_req_t;

	typedef struct packed {
		logic       done;
		logic [9:0] bin;
	} quant_rsp_t;

endpackage

`default_nettype wire

[sv/orientation_histogram_mode_picker.sv]
// ----------------------------------------------------------------------------
// orientation_histogram_mode_picker
// 2D angle histogram with fullest-bin selection and member walk.
// ----------------------------------------------------------------------------
//  port group         direction  meaning
//  in_valid/in_stall  in         one command item per handshake
//  out_valid/out_stall out       one result item per command item
//  cfg_we/cfg_wdata   in         bins per angle axis
//
//  Steps from one accepted item to the next, with a free output register:
//  binned add: two multiply stages, reciprocal stage, bin stage, read,
//  write, hand-off; unbinned add, full add and unused modes: hand-off only.
//  Select reads min(n*n,1024) bin counts, one bin count read per cycle.
//  Next scans from the cursor up to point_total, one stored point read per cycle.
//  Remove: read, write (binned); read (unbinned); clear one bin per cycle.
//  After reset a clearing pass over all bins runs before the first item is taken.
//  A result held by out_stall delays only the hand-off of the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module orientation_histogram_mode_picker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire ohmp_pkg::in_item_t in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output ohmp_pkg::out_item_t     out_item,
	input  wire logic               cfg_we,
	input  wire logic [5:0]         cfg_wdata
);
	import ohmp_pkg::*;

	typedef enum logic [10:0] {
		ST_CLR   = 11'b00000000001,
		ST_IDLE  = 11'b00000000010,
		ST_QWAIT = 11'b00000000100,
		ST_ADDWR = 11'b00000001000,
		ST_SEL   = 11'b00000010000,
		ST_NEXT  = 11'b00000100000,
		ST_REMRD = 11'b00001000000,
		ST_REMWR = 11'b00010000000,
		ST_RESP  = 11'b00100000000,
		ST_SPARE = 11'b01000000000,
		ST_HOLD  = 11'b10000000000
	} state_t;

	// memories: bin counts, and per point {binned, bin}
	logic [CNT_W-1:0] bc_mem [MAX_BINS];
	logic [BIN_W:0]   pb_mem [MAX_POINTS];

	state_t           state_q;
	logic [5:0]       bins_q;
	logic [PT_W:0]    total_q, cursor_q, ptr_q, addr_s1;
	logic             vld_s1;
	logic             chosen_vld_q;
	logic [BIN_W-1:0] chosen_q, bin_q, best_q;
	logic [PT_W-1:0]  id_q;
	logic [CNT_W-1:0] bestc_q, bc_rdata_q;
	logic [BIN_W:0]   pb_rdata_q;
	logic             clr_resp_q;
	out_item_t        res_q, out_q;
	logic             out_valid_q;

	logic             accept;
	logic [5:0]       n_eff;
	logic [4:0]       k_eff;
	logic [11:0]      limit;
	logic             bc_we, pb_we;
	logic [BIN_W-1:0] bc_raddr, bc_waddr;
	logic [CNT_W-1:0] bc_wdata;
	logic [PT_W-1:0]  pb_raddr, pb_waddr;
	logic [BIN_W:0]   pb_wdata;
	logic             full, hit;
	quant_req_t       qreq;
	quant_rsp_t       qrsp;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign full     = (total_q == (PT_W+1)'(MAX_POINTS));
	assign hit      = vld_s1 && (pb_rdata_q == {1'b1, chosen_q});

	always_comb begin
		if (bins_q < 6'd2)       n_eff = 6'd2;
		else if (bins_q > 6'd32) n_eff = 6'd32;
		else                     n_eff = bins_q;
		k_eff = 5'(n_eff - 6'd1);
		limit = 12'(n_eff) * 12'(n_eff);
		if (limit > 12'(MAX_BINS)) limit = 12'(MAX_BINS);
	end

	ohmp_quant u_quant (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (qreq),
		.rsp    (qrsp)
	);

	always_comb begin
		qreq.start   = accept && (in_item.mode == MODE_ADD) && !full && in_item.point_valid;
		qreq.polar   = in_item.polar_angle;
		qreq.azimuth = in_item.azimuth_angle;
		qreq.k       = k_eff;
		qreq.n       = n_eff;
	end

	// memory address and write selection
	always_comb begin
		bc_raddr = ptr_q[BIN_W-1:0];
		bc_we    = 1'b0;
		bc_waddr = bin_q;
		bc_wdata = '0;
		pb_raddr = ptr_q[PT_W-1:0];
		pb_we    = 1'b0;
		pb_waddr = id_q;
		pb_wdata = '0;
		case (state_q)
			ST_CLR: begin
				bc_we    = 1'b1;
				bc_waddr = ptr_q[BIN_W-1:0];
			end
			ST_IDLE: begin
				pb_raddr = in_item.remove_id;
				// unbinned add: store the point with no bin
				if (accept && (in_item.mode == MODE_ADD) && !full && !in_item.point_valid) begin
					pb_we    = 1'b1;
					pb_waddr = total_q[PT_W-1:0];
				end
			end
			ST_QWAIT: bc_raddr = qrsp.bin;
			ST_ADDWR: begin
				bc_we    = 1'b1;
				bc_wdata = (bc_rdata_q == '1) ? bc_rdata_q : bc_rdata_q + 1'b1;
				pb_we    = 1'b1;
				pb_wdata = {1'b1, bin_q};
			end
			ST_REMRD: bc_raddr = pb_rdata_q[BIN_W-1:0];
			ST_REMWR: begin
				bc_we    = (bc_rdata_q != '0);
				bc_wdata = bc_rdata_q - 1'b1;
				pb_we    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bc_we) bc_mem[bc_waddr] <= bc_wdata;
		bc_rdata_q <= bc_mem[bc_raddr];
	end

	always_ff @(posedge clk) begin
		if (pb_we) pb_mem[pb_waddr] <= pb_wdata;
		pb_rdata_q <= pb_mem[pb_raddr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bins_q <= BINS_RESET;
		else if (cfg_we) bins_q <= cfg_wdata;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			total_q      <= '0;
			cursor_q     <= '0;
			chosen_vld_q <= 1'b0;
			ptr_q        <= '0;
			vld_s1       <= 1'b0;
			clr_resp_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the taken result unless a new one is loaded this cycle
			if (out_valid_q && !out_stall && state_q != ST_RESP) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q[BIN_W-1:0] == '1) state_q <= clr_resp_q ? ST_RESP : ST_IDLE;
				end
				ST_IDLE: if (accept) begin
					vld_s1 <= 1'b0;
					case (in_item.mode)
						MODE_ADD: begin
							id_q <= total_q[PT_W-1:0];
							if (full) begin
								res_q   <= '0;
								state_q <= ST_RESP;
							end else begin
								total_q <= total_q + 1'b1;
								res_q   <= {1'b0, {BIN_W{1'b0}}, {CNT_W{1'b0}},
									total_q[PT_W-1:0], 1'b0};
								state_q <= in_item.point_valid ? ST_QWAIT : ST_RESP;
							end
						end
						MODE_SELECT: begin
							res_q   <= '0;
							ptr_q   <= '0;
							bestc_q <= '0;
							best_q  <= '0;
							state_q <= ST_SEL;
						end
						MODE_NEXT: begin
							if (chosen_vld_q) begin
								res_q   <= '0;
								ptr_q   <= cursor_q;
								state_q <= ST_NEXT;
							end else begin
								cursor_q <= total_q;
								res_q    <= {1'b0, {BIN_W{1'b0}}, {CNT_W{1'b0}},
									{PT_W{1'b0}}, 1'b1};
								state_q  <= ST_RESP;
							end
						end
						MODE_REMOVE: begin
							res_q   <= '0;
							id_q    <= in_item.remove_id;
							state_q <= ((PT_W+1)'(in_item.remove_id) < total_q) ? ST_REMRD
								: ST_RESP;
						end
						MODE_CLEAR: begin
							res_q        <= '0;
							ptr_q        <= '0;
							total_q      <= '0;
							cursor_q     <= '0;
							chosen_vld_q <= 1'b0;
							clr_resp_q   <= 1'b1;
							state_q      <= ST_CLR;
						end
						default: begin
							res_q   <= '0;
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_QWAIT: if (qrsp.done) begin
					bin_q   <= qrsp.bin;
					state_q <= ST_ADDWR;
				end
				ST_ADDWR: begin
					res_q   <= {1'b1, bin_q, {CNT_W{1'b0}}, id_q, 1'b0};
					state_q <= ST_RESP;
				end
				ST_SEL: begin
					// issue one bin read per cycle, compare the one that returns
					if (12'(ptr_q) < limit) begin
						ptr_q   <= ptr_q + 1'b1;
						addr_s1 <= ptr_q;
						vld_s1  <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && (bc_rdata_q > bestc_q)) begin
						bestc_q <= bc_rdata_q;
						best_q  <= addr_s1[BIN_W-1:0];
					end
					if (!(12'(ptr_q) < limit) && !vld_s1) begin
						cursor_q <= '0;
						if (bestc_q != '0) begin
							chosen_vld_q <= 1'b1;
							chosen_q     <= best_q;
							res_q        <= {1'b1, best_q, bestc_q, {PT_W{1'b0}}, 1'b0};
						end else begin
							chosen_vld_q <= 1'b0;
							chosen_q     <= '0;
						end
						state_q <= ST_RESP;
					end
				end
				ST_NEXT: begin
					if (hit) begin
						cursor_q <= addr_s1 + 1'b1;
						res_q    <= {1'b1, chosen_q, {CNT_W{1'b0}}, addr_s1[PT_W-1:0], 1'b0};
						state_q  <= ST_RESP;
					end else if (ptr_q < total_q) begin
						ptr_q   <= ptr_q + 1'b1;
						addr_s1 <= ptr_q;
						vld_s1  <= 1'b1;
					end else if (vld_s1) begin
						vld_s1 <= 1'b0;
					end else begin
						cursor_q <= total_q;
						res_q    <= {1'b0, {BIN_W{1'b0}}, {CNT_W{1'b0}}, {PT_W{1'b0}}, 1'b1};
						state_q  <= ST_RESP;
					end
				end
				ST_REMRD: begin
					bin_q   <= pb_rdata_q[BIN_W-1:0];
					state_q <= pb_rdata_q[BIN_W] ? ST_REMWR : ST_RESP;
				end
				ST_REMWR: state_q <= ST_RESP;
				ST_RESP: begin
					// hand off once the output register is free or draining
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						clr_resp_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

[sv/ohmp_quant.sv]
// ----------------------------------------------------------------------------
// ohmp_quant: angle quantizer
// Maps a polar/azimuth pair to a bin index by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module ohmp_quant (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ohmp_pkg::quant_req_t req,
	output ohmp_pkg::quant_rsp_t    rsp
);
	import ohmp_pkg::*;

	typedef enum logic [4:0] {
		Q_IDLE = 5'b00001,
		Q_MUL1 = 5'b00010,
		Q_MUL2 = 5'b00100,
		Q_DIV  = 5'b01000,
		Q_FIN  = 5'b10000
	} qstate_t;

	qstate_t            state_q;
	logic signed [15:0] pol_q, azi_q;
	logic [4:0]         k_q;
	logic [5:0]         n_q;
	logic [19:0]        px_s1;
	logic [22:0]        ayp_s1;
	logic [26:0]        xrem_q;
	logic [27:0]        yrem_q;
	logic [5:0]         qx_q, qy_q;
	logic               done_q;
	logic [9:0]         bin_q;

	logic signed [24:0] ay_w;
	logic [25:0]        xprod, yprod;
	logic [5:0]         yeff;
	logic [4:0]         xs, ys;

	always_comb begin
		ay_w  = 25'(azi_q) * 25'sd100 + 25'(QOFS_Y);
		xprod = 26'(xrem_q[26:QSH_X]) * 26'(QRECIP);
		yprod = 26'(yrem_q[27:QSH_Y]) * 26'(QRECIP);
		yeff  = (qx_q != 6'd0) ? qy_q : 6'd0;
		xs    = (qx_q > {1'b0, k_q}) ? k_q : qx_q[4:0];
		ys    = (yeff > {1'b0, k_q}) ? k_q : yeff[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				Q_IDLE: if (req.start) state_q <= Q_MUL1;
				Q_MUL1: state_q <= Q_MUL2;
				Q_MUL2: state_q <= Q_DIV;
				Q_DIV:  state_q <= Q_FIN;
				Q_FIN: begin
					done_q  <= 1'b1;
					state_q <= Q_IDLE;
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			Q_IDLE: begin
				pol_q <= req.polar;
				azi_q <= req.azimuth;
				k_q   <= req.k;
				n_q   <= req.n;
			end
			Q_MUL1: begin
				px_s1  <= (pol_q > 16'sd0) ? 20'(pol_q[14:0]) * 20'(k_q) : 20'd0;
				ayp_s1 <= (ay_w > 25'sd0) ? ay_w[22:0] : 23'd0;
			end
			Q_MUL2: begin
				xrem_q <= 27'(px_s1) * 27'd100;
				yrem_q <= 28'(ayp_s1) * 28'(k_q);
			end
			Q_DIV: begin
				qx_q <= xprod[QRECIP_SH+5:QRECIP_SH];
				qy_q <= yprod[QRECIP_SH+5:QRECIP_SH];
			end
			Q_FIN: bin_q <= 10'(11'(ys) * 11'(n_q) + 11'(xs));
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.bin  = bin_q;

endmodule

`default_nettype wire
